>>> src/bsrq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsrq_pkg
// Shared constants and types of the bounded sequence ring queue: sizes,
// operation codes, result status codes and controller states.
// ----------------------------------------------------------------------------
package bsrq_pkg;

    // Sizes of the queue and its fields.
    localparam int DEPTH       = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int COUNT_BITS  = 24;
    localparam int SIGNAL_BITS = 8;
    localparam int IDX_BITS    = $clog2(DEPTH);
    localparam int FUNC_BITS   = 3;
    localparam int STATUS_BITS = 2;

    // Operation codes carried in the func field.
    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_PRODUCE          = 3'd0,
        FUNC_CONSUME          = 3'd1,
        FUNC_PROD_SET         = 3'd2,
        FUNC_CONS_SET         = 3'd3,
        FUNC_PROD_SET_COUNT   = 3'd4,
        FUNC_CONS_SET_COUNT   = 3'd5
    } func_t;

    // Result status codes.
    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_REFUSED = 2'd1,
        STATUS_FULL    = 2'd2,
        STATUS_EMPTY   = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

>>> src/bounded_sequence_ring_queue.sv
`timescale 1ns / 1ps
// An accepted item's slot is read from the gate and data memories into registers;
// the item then executes, writes its slot back and loads the output register when
// it commits. The block takes no new item until the held one has committed.
// A stalled result holds the item in execution until the output register frees.
// Reset clears the counts, the signals and the gate valid bits at once; there
// is no clearing pass, so the block takes items right after reset.
// ----------------------------------------------------------------------------
// bounded_sequence_ring_queue
// Ring queue with a sequence gate per slot. Producer and consumer words each
// hold a transaction count and a signal tag; push, pop and compare-and-set
// of the signals are executed one at a time against two slot memories.
// ----------------------------------------------------------------------------
module bounded_sequence_ring_queue (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input channel.
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bsrq_pkg::FUNC_BITS-1:0]    func,
    input  logic [bsrq_pkg::DATA_WIDTH-1:0]   data_in,
    input  logic                              replace_signal,
    input  logic [bsrq_pkg::SIGNAL_BITS-1:0]  new_signal,
    input  logic [bsrq_pkg::SIGNAL_BITS-1:0]  fallback_mask,
    input  logic [bsrq_pkg::SIGNAL_BITS-1:0]  fallback_match,
    input  logic [bsrq_pkg::SIGNAL_BITS-1:0]  expected_signal,
    input  logic [bsrq_pkg::COUNT_BITS-1:0]   expected_count,
    // Output channel.
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bsrq_pkg::STATUS_BITS-1:0]  status,
    output logic [bsrq_pkg::DATA_WIDTH-1:0]   data_out,
    output logic [bsrq_pkg::COUNT_BITS-1:0]   seen_count,
    output logic [bsrq_pkg::SIGNAL_BITS-1:0]  seen_signal
);

    localparam int CB = bsrq_pkg::COUNT_BITS;
    localparam int SB = bsrq_pkg::SIGNAL_BITS;
    localparam int DW = bsrq_pkg::DATA_WIDTH;
    localparam int IB = bsrq_pkg::IDX_BITS;
    localparam int DP = bsrq_pkg::DEPTH;

    // Controller state.
    bsrq_pkg::state_t state_reg, state_next;

    // Queue words.
    logic [CB-1:0] prod_count_reg, prod_count_next;
    logic [SB-1:0] prod_signal_reg, prod_signal_next;
    logic [CB-1:0] cons_count_reg, cons_count_next;
    logic [SB-1:0] cons_signal_reg, cons_signal_next;

    // Gate entries that have been written since reset.
    logic [DP-1:0] gate_valid_reg, gate_valid_next;

    // Item held while it executes.
    bsrq_pkg::func_t item_func_reg;
    logic [DW-1:0]   item_data_reg;
    logic            item_replace_reg;
    logic [SB-1:0]   item_new_sig_reg;
    logic [SB-1:0]   item_mask_reg;
    logic [SB-1:0]   item_match_reg;
    logic [SB-1:0]   item_exp_sig_reg;
    logic [CB-1:0]   item_exp_cnt_reg;
    logic [IB-1:0]   item_idx_reg;

    // Output register.
    logic                          out_valid_reg, out_valid_next;
    logic [bsrq_pkg::STATUS_BITS-1:0] status_reg, status_next;
    logic [DW-1:0]                 data_out_reg, data_out_next;
    logic [CB-1:0]                 seen_count_reg, seen_count_next;
    logic [SB-1:0]                 seen_signal_reg, seen_signal_next;

    // Handshake and control.
    logic          in_accept;
    logic          commit;
    logic [IB-1:0] rd_idx;

    // Memory ports.
    logic          gate_wr_en;
    logic [CB-1:0] gate_wr_data;
    logic [CB-1:0] gate_rd_data;
    logic          data_wr_en;
    logic [DW-1:0] slot_rd_data;

    // Execution results.
    logic [CB-1:0] gate_cur;

    assign in_accept = in_valid && in_ready;
    assign commit    = (state_reg == bsrq_pkg::ST_EXEC) && (!out_valid_reg || out_ready);

    // Slot of the addressed side, taken from its count.
    assign rd_idx = func[0] ? cons_count_reg[IB-1:0] : prod_count_reg[IB-1:0];

    // Gate memory: an entry never written reads as its own index.
    bsrq_ram #(
        .WIDTH (CB),
        .DEPTH (DP)
    ) u_gate_ram (
        .clk     (clk),
        .wr_en   (gate_wr_en),
        .wr_addr (item_idx_reg),
        .wr_data (gate_wr_data),
        .rd_en   (in_accept),
        .rd_addr (rd_idx),
        .rd_data (gate_rd_data)
    );

    // Slot data memory.
    bsrq_ram #(
        .WIDTH (DW),
        .DEPTH (DP)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (data_wr_en),
        .wr_addr (item_idx_reg),
        .wr_data (item_data_reg),
        .rd_en   (in_accept),
        .rd_addr (rd_idx),
        .rd_data (slot_rd_data)
    );

    assign gate_cur = gate_valid_reg[item_idx_reg] ? gate_rd_data : CB'(item_idx_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bsrq_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = bsrq_pkg::ST_EXEC;
                end
            end
            bsrq_pkg::ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = bsrq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bsrq_pkg::ST_IDLE;
            end
        endcase
    end

    // Controller outputs.
    always_comb
    begin
        unique case (state_reg)
            bsrq_pkg::ST_IDLE: in_ready = 1'b1;
            bsrq_pkg::ST_EXEC: in_ready = 1'b0;
            default:           in_ready = 1'b0;
        endcase
    end

    // Execute the held item against the slot read from memory.
    always_comb
    begin
        logic [CB-1:0] c;
        logic [SB-1:0] s;
        logic [CB-1:0] c_inc;
        logic          refused;
        logic          side_ok;
        logic          sig_write;

        c         = item_func_reg[0] ? cons_count_reg : prod_count_reg;
        s         = item_func_reg[0] ? cons_signal_reg : prod_signal_reg;
        c_inc     = c + CB'(1);
        refused   = (s & item_mask_reg) == item_match_reg;
        side_ok   = 1'b0;
        sig_write = 1'b0;

        status_next      = bsrq_pkg::STATUS_REFUSED;
        data_out_next    = '0;
        seen_count_next  = c;
        seen_signal_next = s;
        gate_wr_en       = 1'b0;
        gate_wr_data     = c_inc;
        data_wr_en       = 1'b0;

        unique case (item_func_reg)
            bsrq_pkg::FUNC_PRODUCE:
            begin
                if (refused)
                begin
                    status_next = bsrq_pkg::STATUS_REFUSED;
                end
                else if (gate_cur != c)
                begin
                    status_next = bsrq_pkg::STATUS_FULL;
                end
                else
                begin
                    status_next  = bsrq_pkg::STATUS_OK;
                    side_ok      = 1'b1;
                    gate_wr_en   = commit;
                    gate_wr_data = c_inc;
                    data_wr_en   = commit;
                end
            end
            bsrq_pkg::FUNC_CONSUME:
            begin
                if (refused)
                begin
                    status_next = bsrq_pkg::STATUS_REFUSED;
                end
                else if (gate_cur != c_inc)
                begin
                    status_next = bsrq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    status_next   = bsrq_pkg::STATUS_OK;
                    side_ok       = 1'b1;
                    data_out_next = slot_rd_data;
                    gate_wr_en    = commit;
                    gate_wr_data  = c + CB'(DP);
                end
            end
            bsrq_pkg::FUNC_PROD_SET,
            bsrq_pkg::FUNC_CONS_SET:
            begin
                if (s == item_exp_sig_reg)
                begin
                    status_next = bsrq_pkg::STATUS_OK;
                    sig_write   = 1'b1;
                end
            end
            bsrq_pkg::FUNC_PROD_SET_COUNT,
            bsrq_pkg::FUNC_CONS_SET_COUNT:
            begin
                if ((s == item_exp_sig_reg) && (c == item_exp_cnt_reg))
                begin
                    status_next = bsrq_pkg::STATUS_OK;
                    sig_write   = 1'b1;
                end
            end
            default:
            begin
                // Unused selector: report the producer word and change nothing.
                status_next      = bsrq_pkg::STATUS_REFUSED;
                seen_count_next  = prod_count_reg;
                seen_signal_next = prod_signal_reg;
            end
        endcase

        // Side word updates, applied only when the result is committed.
        prod_count_next  = prod_count_reg;
        prod_signal_next = prod_signal_reg;
        cons_count_next  = cons_count_reg;
        cons_signal_next = cons_signal_reg;
        if (commit && (side_ok || sig_write))
        begin
            if (item_func_reg[0])
            begin
                if (side_ok)
                begin
                    cons_count_next = c_inc;
                end
                if (sig_write || item_replace_reg)
                begin
                    cons_signal_next = item_new_sig_reg;
                end
            end
            else
            begin
                if (side_ok)
                begin
                    prod_count_next = c_inc;
                end
                if (sig_write || item_replace_reg)
                begin
                    prod_signal_next = item_new_sig_reg;
                end
            end
        end

        gate_valid_next = gate_valid_reg;
        if (gate_wr_en)
        begin
            gate_valid_next[item_idx_reg] = 1'b1;
        end
    end

    // Output register valid.
    always_comb
    begin
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bsrq_pkg::ST_IDLE;
            prod_count_reg  <= '0;
            prod_signal_reg <= '0;
            cons_count_reg  <= '0;
            cons_signal_reg <= '0;
            gate_valid_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            prod_count_reg  <= prod_count_next;
            prod_signal_reg <= prod_signal_next;
            cons_count_reg  <= cons_count_next;
            cons_signal_reg <= cons_signal_next;
            gate_valid_reg  <= gate_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Item capture on accept.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_func_reg    <= bsrq_pkg::func_t'(func);
            item_data_reg    <= data_in;
            item_replace_reg <= replace_signal;
            item_new_sig_reg <= new_signal;
            item_mask_reg    <= fallback_mask;
            item_match_reg   <= fallback_match;
            item_exp_sig_reg <= expected_signal;
            item_exp_cnt_reg <= expected_count;
            item_idx_reg     <= rd_idx;
        end
    end

    // Result payload capture on commit.
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            status_reg      <= status_next;
            data_out_reg    <= data_out_next;
            seen_count_reg  <= seen_count_next;
            seen_signal_reg <= seen_signal_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign data_out    = data_out_reg;
    assign seen_count  = seen_count_reg;
    assign seen_signal = seen_signal_reg;

`ifndef NO_ASSERTIONS
    // The queue never holds more items than it has slots.
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        CB'(prod_count_reg - cons_count_reg) <= CB'(DP))
        else $error("queue occupancy exceeds depth");

    // A result appears only after an item has executed.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == bsrq_pkg::ST_EXEC))
        else $error("result without execution");

    // A failed operation leaves both counts untouched.
    a_fail_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && (status_next != bsrq_pkg::STATUS_OK)) |=>
        ($stable(prod_count_reg) && $stable(cons_count_reg)))
        else $error("count changed on failed operation");

    // A successful produce advances the producer count by one.
    a_produce_step: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && (item_func_reg == bsrq_pkg::FUNC_PRODUCE) &&
         (status_next == bsrq_pkg::STATUS_OK)) |=>
        (prod_count_reg == CB'($past(prod_count_reg) + CB'(1))))
        else $error("producer count not advanced");
`endif

endmodule

>>> src/bsrq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsrq_ram
// Generic single-clock RAM with one write port and one read port. The read
// data is registered and holds its value while no read is issued.
// ----------------------------------------------------------------------------
module bsrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
